// ===== src/bgbd_pkg.sv =====
// Shared types, constants and helper functions of the Bayer GBRG demosaic block.
`default_nettype none

package bgbd_pkg;

    localparam int SAMPLE_W      = 8;
    localparam int PIX_W         = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 13;
    localparam int WIDTH_FIELD_W = 12;
    localparam int HEIGHT_FIELD_W = 13;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int WIDTH_RESET    = 640;
    localparam int HEIGHT_RESET   = 480;
    localparam int DIM_MIN        = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef logic [1:0] color_t;
    localparam color_t CLR_RED   = 2'd0;
    localparam color_t CLR_GREEN = 2'd1;
    localparam color_t CLR_BLUE  = 2'd2;

    // Position flags of the output site inside the frame.
    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
        logic row_odd;
        logic col_odd;
        logic frame_end;
    } pos_t;

    // Even rows carry G,B and odd rows carry R,G.
    function automatic color_t site_color(input logic row_odd, input logic col_odd);
        color_t c;
        if (!row_odd)
        begin
            c = col_odd ? CLR_BLUE : CLR_GREEN;
        end
        else
        begin
            c = col_odd ? CLR_GREEN : CLR_RED;
        end
        return c;
    endfunction

    // Floor of sum / cnt for a count of one to four; three uses a reciprocal.
    function automatic logic [PIX_W-1:0] mean_div(input logic [10:0] sum,
                                                  input logic [2:0] cnt);
        logic [21:0]      prod;
        logic [PIX_W-1:0] q;
        prod = 22'(sum) * 22'd683;
        case (cnt)
            3'd1:    q = sum[7:0];
            3'd2:    q = sum[8:1];
            3'd3:    q = prod[18:11];
            3'd4:    q = sum[9:2];
            default: q = '0;
        endcase
        return q;
    endfunction

endpackage

`default_nettype wire

// ===== src/bgbd_if.sv =====
// Stream interfaces for mosaic samples in and RGB pixels out.
`default_nettype none

interface bgbd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [bgbd_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output op, output sample, input ready);
    modport sink (input valid, input op, input sample, output ready);
endinterface

interface bgbd_out_if;
    logic                       valid;
    logic                       ready;
    logic [bgbd_pkg::PIX_W-1:0] red;
    logic [bgbd_pkg::PIX_W-1:0] green;
    logic [bgbd_pkg::PIX_W-1:0] blue;
    logic                       frame_end;

    modport source (output valid, output red, output green, output blue,
                    output frame_end, input ready);
    modport sink (input valid, input red, input green, input blue,
                  input frame_end, output ready);
endinterface

`default_nettype wire

// ===== src/bgbd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bgbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/bgbd_seq.sv =====
// Frame geometry registers, raster position counters and the first pipeline stage.
`default_nettype none

module bgbd_seq #(
    parameter int MAX_WIDTH  = bgbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bgbd_pkg::MAX_HEIGHT_DEF,
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int RW         = $clog2(MAX_HEIGHT + 8)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bgbd_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [bgbd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic                                op,
    input  logic [bgbd_pkg::SAMPLE_W-1:0]       sample,
    output logic                                rd_en,
    output logic [CW-1:0]                       rd_addr,
    output logic                                s1_proc,
    output logic                                s1_emit,
    output logic [bgbd_pkg::SAMPLE_W-1:0]       s1_sample,
    output logic [CW-1:0]                       s1_col,
    output bgbd_pkg::pos_t                      s1_pos
);

    localparam int WW = CW + 1;
    localparam int WRst = (bgbd_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                              : bgbd_pkg::WIDTH_RESET;
    localparam int HRst = (bgbd_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                                : bgbd_pkg::HEIGHT_RESET;

    logic [WW-1:0] w_reg, w_next;
    logic [RW-1:0] h_reg, h_next;
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;

    logic                          s1_proc_reg;
    logic                          s1_emit_reg;
    logic [bgbd_pkg::SAMPLE_W-1:0] s1_sample_reg;
    logic [CW-1:0]                 s1_col_reg;
    bgbd_pkg::pos_t                s1_pos_reg;

    logic                          acc;
    logic                          new_frame;
    logic [CW-1:0]                 ic, oc;
    logic [RW-1:0]                 ir, orow;
    logic                          proc;
    logic                          emit;
    logic [bgbd_pkg::SAMPLE_W-1:0] s_eff;
    logic [WW-1:0]                 ic_inc, oc_inc;
    logic                          ic_wrap, oc_wrap;
    logic [RW-1:0]                 orow_inc;
    bgbd_pkg::pos_t                pos;
    int                            wv, hv;

    // Register writes are clamped to the supported geometry when stored.
    always_comb
    begin
        wv = 32'(cfg_data[bgbd_pkg::WIDTH_FIELD_W-1:0]);
        hv = 32'(cfg_data[bgbd_pkg::HEIGHT_FIELD_W-1:0]);
        if (wv < bgbd_pkg::DIM_MIN)
        begin
            wv = bgbd_pkg::DIM_MIN;
        end
        if (wv > MAX_WIDTH)
        begin
            wv = MAX_WIDTH;
        end
        if (hv < bgbd_pkg::DIM_MIN)
        begin
            hv = bgbd_pkg::DIM_MIN;
        end
        if (hv > MAX_HEIGHT)
        begin
            hv = MAX_HEIGHT;
        end
        w_next = w_reg;
        h_next = h_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                bgbd_pkg::REG_WIDTH:  w_next = WW'(wv);
                bgbd_pkg::REG_HEIGHT: h_next = RW'(hv);
                default:              w_next = w_reg;
            endcase
        end
    end

    always_comb
    begin
        acc       = in_valid && en;
        new_frame = (op == bgbd_pkg::OP_SAMPLE) && (out_row_reg >= h_reg);
        ic   = new_frame ? '0 : in_col_reg;
        ir   = new_frame ? '0 : in_row_reg;
        oc   = new_frame ? '0 : out_col_reg;
        orow = new_frame ? '0 : out_row_reg;

        if (ir < h_reg)
        begin
            proc  = (op == bgbd_pkg::OP_SAMPLE);
            s_eff = sample;
        end
        else
        begin
            proc  = (orow < h_reg);
            s_eff = '0;
        end

        emit = proc && ((ir >= RW'(2)) || ((ir == RW'(1)) && (ic != '0)))
                    && (orow < h_reg);

        ic_inc   = {1'b0, ic} + WW'(1);
        ic_wrap  = (ic_inc >= w_reg);
        oc_inc   = {1'b0, oc} + WW'(1);
        oc_wrap  = (oc_inc >= w_reg);
        orow_inc = orow + RW'(1);

        pos.top       = (orow == '0);
        pos.bot       = (orow_inc >= h_reg);
        pos.left      = (oc == '0);
        pos.right     = oc_wrap;
        pos.row_odd   = orow[0];
        pos.col_odd   = oc[0];
        pos.frame_end = (orow_inc == h_reg) && oc_wrap;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (acc && proc)
        begin
            if (ic_wrap)
            begin
                in_col_next = '0;
                in_row_next = ir + RW'(1);
            end
            else
            begin
                in_col_next = ic_inc[CW-1:0];
                in_row_next = ir;
            end
            if (emit)
            begin
                if (oc_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = orow_inc;
                end
                else
                begin
                    out_col_next = oc_inc[CW-1:0];
                    out_row_next = orow;
                end
            end
            else
            begin
                out_col_next = oc;
                out_row_next = orow;
            end
        end

        rd_en   = acc && proc;
        rd_addr = ic;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg       <= WW'(WRst);
            h_reg       <= RW'(HRst);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            s1_proc_reg <= 1'b0;
            s1_emit_reg <= 1'b0;
        end
        else
        begin
            w_reg       <= w_next;
            h_reg       <= h_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (en)
            begin
                s1_proc_reg <= acc && proc;
                s1_emit_reg <= acc && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sample_reg <= s_eff;
            s1_col_reg    <= ic;
            s1_pos_reg    <= pos;
        end
    end

    assign s1_proc   = s1_proc_reg;
    assign s1_emit   = s1_emit_reg;
    assign s1_sample = s1_sample_reg;
    assign s1_col    = s1_col_reg;
    assign s1_pos    = s1_pos_reg;

endmodule

`default_nettype wire

// ===== src/bgbd_interp.sv =====
// 3x3 neighborhood window, bilinear interpolation and the output register.
`default_nettype none

module bgbd_interp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          s1_proc,
    input  logic                          s1_emit,
    input  logic [bgbd_pkg::SAMPLE_W-1:0] s1_sample,
    input  bgbd_pkg::pos_t                s1_pos,
    input  logic [bgbd_pkg::PIX_W-1:0]    above,
    input  logic [bgbd_pkg::PIX_W-1:0]    current,
    output logic                          out_valid,
    output logic [bgbd_pkg::PIX_W-1:0]    red,
    output logic [bgbd_pkg::PIX_W-1:0]    green,
    output logic [bgbd_pkg::PIX_W-1:0]    blue,
    output logic                          frame_end
);

    logic [bgbd_pkg::PIX_W-1:0] win_reg [3][3];
    logic                       s2_emit_reg;
    bgbd_pkg::pos_t             s2_pos_reg;
    logic                       out_valid_reg;
    logic [bgbd_pkg::PIX_W-1:0] red_reg, green_reg, blue_reg;
    logic                       frame_end_reg;

    logic [10:0]                sum_r, sum_g, sum_b;
    logic [2:0]                 cnt_r, cnt_g, cnt_b;
    logic [bgbd_pkg::PIX_W-1:0] red_next, green_next, blue_next;
    logic                       use_px;
    bgbd_pkg::color_t           clr;
    bgbd_pkg::color_t           own;

    always_ff @(posedge clk)
    begin
        if (en && s1_proc)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= above;
            win_reg[1][2] <= current;
            win_reg[2][2] <= s1_sample;
        end
    end

    // Neighbors outside the frame are left out of each mean.
    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        cnt_r = '0;
        cnt_g = '0;
        cnt_b = '0;
        use_px = 1'b0;
        clr = bgbd_pkg::CLR_GREEN;
        for (int dr = 0; dr < 3; dr++)
        begin
            for (int dc = 0; dc < 3; dc++)
            begin
                use_px = !((dr == 0) && s2_pos_reg.top) && !((dr == 2) && s2_pos_reg.bot)
                      && !((dc == 0) && s2_pos_reg.left) && !((dc == 2) && s2_pos_reg.right);
                clr = bgbd_pkg::site_color(s2_pos_reg.row_odd ^ (dr != 1),
                                           s2_pos_reg.col_odd ^ (dc != 1));
                if (use_px)
                begin
                    case (clr)
                        bgbd_pkg::CLR_RED:
                        begin
                            sum_r = sum_r + 11'(win_reg[dr][dc]);
                            cnt_r = cnt_r + 3'd1;
                        end
                        bgbd_pkg::CLR_BLUE:
                        begin
                            sum_b = sum_b + 11'(win_reg[dr][dc]);
                            cnt_b = cnt_b + 3'd1;
                        end
                        default:
                        begin
                            sum_g = sum_g + 11'(win_reg[dr][dc]);
                            cnt_g = cnt_g + 3'd1;
                        end
                    endcase
                end
            end
        end

        own = bgbd_pkg::site_color(s2_pos_reg.row_odd, s2_pos_reg.col_odd);
        red_next   = bgbd_pkg::mean_div(sum_r, cnt_r);
        green_next = bgbd_pkg::mean_div(sum_g, cnt_g);
        blue_next  = bgbd_pkg::mean_div(sum_b, cnt_b);
        case (own)
            bgbd_pkg::CLR_RED:  red_next = win_reg[1][1];
            bgbd_pkg::CLR_BLUE: blue_next = win_reg[1][1];
            default:            green_next = win_reg[1][1];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_emit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_emit_reg   <= s1_emit;
            out_valid_reg <= s2_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_pos_reg <= s1_pos;
            if (s2_emit_reg)
            begin
                red_reg       <= red_next;
                green_reg     <= green_next;
                blue_reg      <= blue_next;
                frame_end_reg <= s2_pos_reg.frame_end;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign frame_end = frame_end_reg;

endmodule

`default_nettype wire

// ===== src/bayer_gbrg_bilinear_demosaic.sv =====
// Top level of the bilinear GBRG Bayer demosaic: line buffer, sequencer and interpolator.
// Throughput is one beat per cycle; a stall on the pixel output holds every stage.
// A sample beat passes the line-buffer read, the window load and then interpolation on its
// way to the pixel register; a pixel leaves one row plus one site behind its sample.
// Reset clears the counters and pipeline valids and sets the size to 640 x 480;
// the line buffer is not cleared, rows above the frame are masked instead.
`default_nettype none

module bayer_gbrg_bilinear_demosaic #(
    parameter int MAX_WIDTH  = bgbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bgbd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bgbd_in_if.sink                         pix_in,
    bgbd_out_if.source                      pix_out,
    input  logic                            cfg_we,
    input  logic [bgbd_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [bgbd_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 8);
    localparam int PW = bgbd_pkg::PIX_W;

    logic                          en;
    logic                          out_valid;
    logic                          rd_en;
    logic [CW-1:0]                 rd_addr;
    logic                          s1_proc;
    logic                          s1_emit;
    logic [bgbd_pkg::SAMPLE_W-1:0] s1_sample;
    logic [CW-1:0]                 s1_col;
    bgbd_pkg::pos_t                s1_pos;
    logic [2*PW-1:0]               rd_data;
    logic [2*PW-1:0]               wr_data;

    assign en           = !out_valid || pix_out.ready;
    assign pix_in.ready = en;
    assign pix_out.valid = out_valid;

    // Each line-buffer word holds the two rows above the incoming sample.
    assign wr_data = {rd_data[PW-1:0], s1_sample};

    bgbd_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .en        (en),
        .in_valid  (pix_in.valid),
        .op        (pix_in.op),
        .sample    (pix_in.sample),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .s1_proc   (s1_proc),
        .s1_emit   (s1_emit),
        .s1_sample (s1_sample),
        .s1_col    (s1_col),
        .s1_pos    (s1_pos)
    );

    bgbd_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk   (clk),
        .we    (en && s1_proc),
        .waddr (s1_col),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    bgbd_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .s1_proc   (s1_proc),
        .s1_emit   (s1_emit),
        .s1_sample (s1_sample),
        .s1_pos    (s1_pos),
        .above     (rd_data[2*PW-1:PW]),
        .current   (rd_data[PW-1:0]),
        .out_valid (out_valid),
        .red       (pix_out.red),
        .green     (pix_out.green),
        .blue      (pix_out.blue),
        .frame_end (pix_out.frame_end)
    );

endmodule

`default_nettype wire

// ===== bench/tb_bayer_gbrg_bilinear_demosaic.sv =====
// Self-checking testbench for the GBRG bilinear demosaic: directed table, random frames, predictor.
`default_nettype none

module tb_bayer_gbrg_bilinear_demosaic;
    timeunit 1ns;
    timeprecision 1ps;

    import bgbd_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_end;
    } pixel_t;

    typedef enum logic [1:0] {
        BY_MODEL,
        NO_PIXEL,
        TYPED_PIXEL
    } outcome_t;

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] sample;
        outcome_t            outcome;
        pixel_t              px;
    } stim_row_t;

    localparam int          QUIET_LIMIT  = 1000;
    localparam int unsigned RANDOM_ITEMS = 900;
    localparam int          N_ROWS       = 24;

    localparam pixel_t WHITE_PX     = '{8'd255, 8'd255, 8'd255, 1'b0};
    localparam pixel_t WHITE_END_PX = '{8'd255, 8'd255, 8'd255, 1'b1};
    localparam pixel_t BLACK_PX     = '{8'd0, 8'd0, 8'd0, 1'b0};
    localparam pixel_t BLACK_END_PX = '{8'd0, 8'd0, 8'd0, 1'b1};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    bgbd_in_if  pix_in ();
    bgbd_out_if pix_out ();

    bayer_gbrg_bilinear_demosaic u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix_in),
        .pix_out  (pix_out),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor state: registers, line buffers, 3x3 window and position counters.
    logic [WIDTH_FIELD_W-1:0]  cols_cfg;
    logic [HEIGHT_FIELD_W-1:0] rows_cfg;
    bit [SAMPLE_W-1:0] line_older [MAX_WIDTH_DEF];
    bit [SAMPLE_W-1:0] line_newer [MAX_WIDTH_DEF];
    bit [SAMPLE_W-1:0] nbhd [9];
    int unsigned feed_col, feed_row, pix_col, pix_row;

    pixel_t      pixels_due [$];
    int unsigned mismatches;
    int unsigned fed_items;
    int          quiet;
    int          stall_left;
    bit          idling_on;
    outcome_t    row_outcome;
    pixel_t      row_pixel;

    stim_row_t directed_rows [N_ROWS] = '{
        '{OP_FLUSH,  8'd0,   NO_PIXEL,    '0},
        '{OP_SAMPLE, 8'd255, NO_PIXEL,    '0},
        '{OP_SAMPLE, 8'd255, NO_PIXEL,    '0},
        '{OP_SAMPLE, 8'd255, NO_PIXEL,    '0},
        '{OP_SAMPLE, 8'd255, TYPED_PIXEL, WHITE_PX},
        '{OP_FLUSH,  8'd0,   TYPED_PIXEL, WHITE_PX},
        '{OP_FLUSH,  8'd255, TYPED_PIXEL, WHITE_PX},
        '{OP_FLUSH,  8'd0,   TYPED_PIXEL, WHITE_END_PX},
        '{OP_FLUSH,  8'd255, NO_PIXEL,    '0},
        '{OP_SAMPLE, 8'd0,   NO_PIXEL,    '0},
        '{OP_SAMPLE, 8'd0,   NO_PIXEL,    '0},
        '{OP_SAMPLE, 8'd0,   NO_PIXEL,    '0},
        '{OP_SAMPLE, 8'd0,   TYPED_PIXEL, BLACK_PX},
        '{OP_SAMPLE, 8'd77,  TYPED_PIXEL, BLACK_PX},
        '{OP_FLUSH,  8'd0,   TYPED_PIXEL, BLACK_PX},
        '{OP_FLUSH,  8'd0,   TYPED_PIXEL, BLACK_END_PX},
        '{OP_SAMPLE, 8'd255, BY_MODEL,    '0},
        '{OP_SAMPLE, 8'd0,   BY_MODEL,    '0},
        '{OP_SAMPLE, 8'd0,   BY_MODEL,    '0},
        '{OP_SAMPLE, 8'd255, BY_MODEL,    '0},
        '{OP_FLUSH,  8'd0,   BY_MODEL,    '0},
        '{OP_FLUSH,  8'd0,   BY_MODEL,    '0},
        '{OP_FLUSH,  8'd0,   BY_MODEL,    '0},
        '{OP_FLUSH,  8'd0,   NO_PIXEL,    '0}
    };

    function automatic int unsigned used_cols();
        int unsigned v;
        v = cols_cfg;
        if (v < DIM_MIN)
        begin
            v = DIM_MIN;
        end
        if (v > MAX_WIDTH_DEF)
        begin
            v = MAX_WIDTH_DEF;
        end
        return v;
    endfunction

    function automatic int unsigned used_rows();
        int unsigned v;
        v = rows_cfg;
        if (v < DIM_MIN)
        begin
            v = DIM_MIN;
        end
        if (v > MAX_HEIGHT_DEF)
        begin
            v = MAX_HEIGHT_DEF;
        end
        return v;
    endfunction

    function automatic color_t hue_at(input int unsigned row, input int unsigned col);
        if (row[0] == 1'b0)
        begin
            return col[0] ? CLR_BLUE : CLR_GREEN;
        end
        return col[0] ? CLR_GREEN : CLR_RED;
    endfunction

    function automatic bit demosaic_step(input logic op, input logic [SAMPLE_W-1:0] s_in,
                                         output pixel_t px);
        int unsigned w, h, col, k, dr, dc, rr, cc;
        int unsigned sum [3];
        int unsigned cnt [3];
        logic [SAMPLE_W-1:0] s, above, here;
        logic [PIX_W-1:0] chan [3];
        color_t own, hue;
        bit emit;
        w = used_cols();
        h = used_rows();
        s = s_in;
        px = '0;
        if (op == OP_SAMPLE && pix_row >= h)
        begin
            feed_col = 0;
            feed_row = 0;
            pix_col = 0;
            pix_row = 0;
            for (k = 0; k < 9; k++)
            begin
                nbhd[k] = '0;
            end
        end
        if (feed_row < h)
        begin
            if (op == OP_FLUSH)
            begin
                return 1'b0;
            end
        end
        else
        begin
            if (pix_row >= h)
            begin
                return 1'b0;
            end
            s = '0;
        end

        col = (feed_col >= MAX_WIDTH_DEF) ? 0 : feed_col;
        above = line_older[col];
        here = line_newer[col];
        line_older[col] = here;
        line_newer[col] = s;
        for (k = 0; k < 3; k++)
        begin
            nbhd[k*3] = nbhd[k*3+1];
            nbhd[k*3+1] = nbhd[k*3+2];
        end
        nbhd[2] = above;
        nbhd[5] = here;
        nbhd[8] = s;

        emit = (feed_row >= 2 || (feed_row == 1 && feed_col >= 1)) && pix_row < h;
        if (feed_col + 1 >= w)
        begin
            feed_col = 0;
            if (feed_row < 32'hFFFF)
            begin
                feed_row++;
            end
        end
        else
        begin
            feed_col++;
        end
        if (!emit)
        begin
            return 1'b0;
        end

        for (k = 0; k < 3; k++)
        begin
            sum[k] = 0;
            cnt[k] = 0;
        end
        // Neighbor (dr, dc) sits at row pix_row+dr-1 and column pix_col+dc-1.
        for (dr = 0; dr < 3; dr++)
        begin
            rr = pix_row + dr;
            if (rr >= 1 && rr <= h)
            begin
                for (dc = 0; dc < 3; dc++)
                begin
                    cc = pix_col + dc;
                    if (cc >= 1 && cc <= w)
                    begin
                        hue = hue_at(rr - 1, cc - 1);
                        sum[hue] += nbhd[dr*3+dc];
                        cnt[hue]++;
                    end
                end
            end
        end
        for (k = 0; k < 3; k++)
        begin
            chan[k] = (cnt[k] != 0) ? PIX_W'(sum[k] / cnt[k]) : '0;
        end
        own = hue_at(pix_row, pix_col);
        chan[own] = nbhd[4];

        px.red = chan[CLR_RED];
        px.green = chan[CLR_GREEN];
        px.blue = chan[CLR_BLUE];
        px.frame_end = (pix_row + 1 == h && pix_col + 1 >= w);

        if (pix_col + 1 >= w)
        begin
            pix_col = 0;
            pix_row++;
        end
        else
        begin
            pix_col++;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 100)
        begin
            $display("%0t: %s", $time, what);
        end
    endtask

    always @(posedge clk)
    begin
        pixel_t px;
        pixel_t want;
        bit     made;
        bit     took;
        if (rst_n)
        begin
            took = 1'b0;
            if (pix_in.valid && pix_in.ready)
            begin
                took = 1'b1;
                made = demosaic_step(pix_in.op, pix_in.sample, px);
                case (row_outcome)
                    BY_MODEL:
                    begin
                        if (made)
                        begin
                            pixels_due.push_back(px);
                        end
                    end
                    TYPED_PIXEL: pixels_due.push_back(row_pixel);
                    default: ;
                endcase
            end
            if (pix_out.valid && pix_out.ready)
            begin
                took = 1'b1;
                if (pixels_due.size() == 0)
                begin
                    report_mismatch("pixel beat with none expected");
                end
                else
                begin
                    want = pixels_due.pop_front();
                    if (pix_out.red !== want.red)
                    begin
                        report_mismatch($sformatf("red got %0d want %0d",
                                                  pix_out.red, want.red));
                    end
                    if (pix_out.green !== want.green)
                    begin
                        report_mismatch($sformatf("green got %0d want %0d",
                                                  pix_out.green, want.green));
                    end
                    if (pix_out.blue !== want.blue)
                    begin
                        report_mismatch($sformatf("blue got %0d want %0d",
                                                  pix_out.blue, want.blue));
                    end
                    if (pix_out.frame_end !== want.frame_end)
                    begin
                        report_mismatch($sformatf("frame_end got %0b want %0b",
                                                  pix_out.frame_end, want.frame_end));
                    end
                end
            end
            quiet = took ? 0 : quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            pix_out.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            pix_out.ready <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end
        else
        begin
            pix_out.ready <= 1'b1;
        end
    end

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        if (idx == REG_WIDTH)
        begin
            cols_cfg = val[WIDTH_FIELD_W-1:0];
        end
        else
        begin
            rows_cfg = val[HEIGHT_FIELD_W-1:0];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] s,
                             input outcome_t how, input pixel_t want);
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.op <= op;
        pix_in.sample <= s;
        row_outcome <= how;
        row_pixel <= want;
        @(posedge clk);
        while (!pix_in.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        fed_items++;
    endtask

    // Feeds samples until the frame is in, then mostly flush beats until its last pixel is out.
    task automatic run_frame();
        do
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_item(OP_FLUSH, rand_sample(), BY_MODEL, '0);
            end
            send_item(OP_SAMPLE, rand_sample(), BY_MODEL, '0);
        end
        while (feed_row < used_rows());
        while (pix_row < used_rows())
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                send_item(OP_SAMPLE, rand_sample(), BY_MODEL, '0);
            end
            else
            begin
                send_item(OP_FLUSH, rand_sample(), BY_MODEL, '0);
            end
        end
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 2)) send_item(OP_FLUSH, rand_sample(), BY_MODEL, '0);
        end
    endtask

    task automatic settle();
        pix_in.valid <= 1'b0;
        while (pixels_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    logic [CFG_DATA_W-1:0] corner_cols [4] = '{13'd2048, 13'd1, 13'd4095, 13'd0};
    logic [CFG_DATA_W-1:0] corner_rows [4] = '{13'd1, 13'd4096, 13'd0, 13'd8191};

    initial
    begin
        int unsigned base;
        int unsigned sel;
        pix_in.valid = 1'b0;
        pix_in.op = OP_SAMPLE;
        pix_in.sample = '0;
        pix_out.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_WIDTH;
        cfg_data = '0;
        row_outcome = BY_MODEL;
        row_pixel = '0;
        cols_cfg = WIDTH_FIELD_W'(WIDTH_RESET);
        rows_cfg = HEIGHT_FIELD_W'(HEIGHT_RESET);
        mismatches = 0;
        fed_items = 0;
        quiet = 0;
        stall_left = 0;
        idling_on = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(REG_WIDTH, 13'd2);
        write_reg(REG_HEIGHT, 13'd2);
        idling_on = 1'b1;
        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].op, directed_rows[i].sample,
                      directed_rows[i].outcome, directed_rows[i].px);
        end
        settle();

        foreach (corner_cols[i])
        begin
            write_reg(REG_WIDTH, corner_cols[i]);
            write_reg(REG_HEIGHT, corner_rows[i]);
            run_frame();
            settle();
        end

        base = fed_items;
        sel = 2;
        while (fed_items - base < RANDOM_ITEMS)
        begin
            if (sel != 1)
            begin
                write_reg(REG_WIDTH, ($urandom_range(0, 7) == 0) ?
                          CFG_DATA_W'($urandom_range(11, 40)) :
                          CFG_DATA_W'($urandom_range(2, 10)));
            end
            if (sel != 0)
            begin
                write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(2, 8)));
            end
            repeat ($urandom_range(1, 3)) run_frame();
            settle();
            idling_on = ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 3);
        end

        idling_on = 1'b0;
        write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(2, 12)));
        write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(2, 6)));
        repeat (2) run_frame();
        settle();

        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
